>>> design/pcr_pkg.sv
// Shared constants and derived widths for the packet check and relay block.
package pcr_pkg;

    // Depth of the payload buffer; incoming size bytes are clamped to it.
    localparam int PAYLOAD_MAX = 16;

    localparam int BYTE_W  = 8;
    localparam int PAY_AW  = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int SIZE_W  = $clog2(PAYLOAD_MAX + 1);
    localparam int POS_W   = $clog2(PAYLOAD_MAX + 4);
    localparam int CNT_W   = $clog2(PAYLOAD_MAX + 9);

    // Configuration register indexes.
    localparam logic CFG_DEVICE_TYPE = 1'b0;
    localparam logic CFG_PARENT_SIZE = 1'b1;

    // Operation codes of an input request.
    localparam logic OP_LINK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Destination codes of a result byte.
    localparam logic DEST_PARENT   = 1'b0;
    localparam logic DEST_NEIGHBOR = 1'b1;

    // Fixed bytes of the error packet.
    localparam logic [BYTE_W-1:0] ERR_SIZE_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] ERR_CODE_BYTE = 8'hFF;

    // Reset value of the received checksum.
    localparam logic [BYTE_W-1:0] CHECKSUM_RESET = 8'hFF;

endpackage

>>> design/packet_check_and_relay.sv
// Top level of the packet check and relay block: link parser, payload buffer and byte sequencer.

// A user of this block should know first that it works on one request at a time. A link byte
// or a converter sample is taken only while the block is idle. A sample only
// updates the running average (half the old value plus half the sample) and gives no result.
// Link bytes are parsed as type, size, number, checksum and then size payload bytes, the size
// being clamped to the payload buffer depth. The byte that completes a packet leads to a
// check state for the checksum compare, after which a single byte sequencer hands out one
// result byte per cycle through the output register while the downstream side does not stall:
// four bytes for an error packet, or five parent bytes followed by four header bytes and size
// payload bytes to the neighbour on a match, so at most 25 result bytes. The sequencer reads the
// payload buffer through its one registered read port, one entry per result byte, and in_stall
// stays high until the final byte has been loaded into the output register. The next request can
// therefore be taken while that final byte still waits to be collected.
module packet_check_and_relay
    import pcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [BYTE_W-1:0] value,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              dest,
    output logic [BYTE_W-1:0] data,
    output logic              end_of_packet,
    output logic              last,

    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    // Parser positions within an incoming packet.
    localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SIZE     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_NUMBER   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(4);

    // Result byte slots of the sequencer count.
    localparam logic [CNT_W-1:0] C_DEV     = CNT_W'(0);
    localparam logic [CNT_W-1:0] C_PSIZE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] C_PNUM    = CNT_W'(2);
    localparam logic [CNT_W-1:0] C_PSUM    = CNT_W'(3);
    localparam logic [CNT_W-1:0] C_PAVG    = CNT_W'(4);
    localparam logic [CNT_W-1:0] C_NTYPE   = CNT_W'(5);
    localparam logic [CNT_W-1:0] C_NSIZE   = CNT_W'(6);
    localparam logic [CNT_W-1:0] C_NNUM    = CNT_W'(7);
    localparam logic [CNT_W-1:0] C_NCHK    = CNT_W'(8);
    localparam logic [CNT_W-1:0] C_PAYLOAD = CNT_W'(9);
    localparam logic [CNT_W-1:0] C_ERR_END = CNT_W'(3);

    // Configuration registers.
    logic [BYTE_W-1:0] dev_type_reg;
    logic [BYTE_W-1:0] parent_size_reg;

    // Parser and packet state.
    logic [1:0]        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] avg_reg, avg_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [BYTE_W-1:0] number_reg, number_next;
    logic [BYTE_W-1:0] checksum_reg, checksum_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              match_reg, match_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Payload buffer and its registered read port.
    logic [BYTE_W-1:0] payload_mem [PAYLOAD_MAX];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [PAY_AW-1:0] mem_waddr;
    logic [PAY_AW-1:0] mem_raddr;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic              dest_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              eop_reg;
    logic              last_reg;

    // Helper signals.
    logic              in_accept;
    logic              out_load;
    logic [SIZE_W-1:0] size_clamped;
    logic [POS_W-1:0]  pay_idx;
    logic [CNT_W-1:0]  match_end_cnt;
    logic              emit_dest;
    logic [BYTE_W-1:0] emit_data;
    logic              emit_eop;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // The output register can take a new byte when it is empty or being emptied this cycle.
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign size_clamped = (value > BYTE_W'(PAYLOAD_MAX)) ? SIZE_W'(PAYLOAD_MAX)
                                                         : value[SIZE_W-1:0];
    assign pay_idx       = pos_reg - POS_PAYLOAD;
    assign match_end_cnt = CNT_W'(size_reg) + C_NCHK;

    // The payload entry addressed is the one for the next sequencer count, so the
    // registered read data lines up with the sequencer count.
    assign mem_raddr = PAY_AW'(cnt_next - C_PAYLOAD);
    assign mem_waddr = pay_idx[PAY_AW-1:0];

    // Selection of the result byte for the current sequencer count.
    always_comb
    begin
        emit_dest = DEST_PARENT;
        emit_data = rd_data_reg;
        emit_eop  = 1'b0;
        if (match_reg)
        begin
            case (cnt_reg)
                C_DEV:   emit_data = dev_type_reg;
                C_PSIZE: emit_data = parent_size_reg;
                C_PNUM:  emit_data = number_reg;
                C_PSUM:  emit_data = dev_type_reg ^ parent_size_reg ^ number_reg ^ avg_reg;
                C_PAVG:
                begin
                    emit_data = avg_reg;
                    emit_eop  = 1'b1;
                end
                C_NTYPE:
                begin
                    emit_dest = DEST_NEIGHBOR;
                    emit_data = type_reg;
                end
                C_NSIZE:
                begin
                    emit_dest = DEST_NEIGHBOR;
                    emit_data = BYTE_W'(size_reg);
                end
                C_NNUM:
                begin
                    emit_dest = DEST_NEIGHBOR;
                    emit_data = number_reg;
                end
                C_NCHK:
                begin
                    emit_dest = DEST_NEIGHBOR;
                    emit_data = checksum_reg;
                    emit_eop  = (size_reg == '0);
                end
                default:
                begin
                    emit_dest = DEST_NEIGHBOR;
                    emit_data = rd_data_reg;
                    emit_eop  = (cnt_reg == match_end_cnt);
                end
            endcase
        end
        else
        begin
            case (cnt_reg)
                C_DEV:   emit_data = dev_type_reg;
                C_PSIZE: emit_data = ERR_SIZE_BYTE;
                C_PNUM:  emit_data = ERR_CODE_BYTE;
                default:
                begin
                    emit_data = dev_type_reg ^ ERR_CODE_BYTE;
                    emit_eop  = 1'b1;
                end
            endcase
        end
    end

    // Parser, check and sequencer control.
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        avg_next      = avg_reg;
        type_next     = type_reg;
        size_next     = size_reg;
        number_next   = number_reg;
        checksum_next = checksum_reg;
        xor_next      = xor_reg;
        match_next    = match_reg;
        cnt_next      = cnt_reg;
        mem_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_SAMPLE)
                    begin
                        avg_next = (avg_reg >> 1) + (value >> 1);
                    end
                    else
                    begin
                        case (pos_reg)
                            POS_TYPE:
                            begin
                                type_next = value;
                                xor_next  = value;
                                pos_next  = POS_SIZE;
                            end
                            POS_SIZE:
                            begin
                                size_next = size_clamped;
                                xor_next  = xor_reg ^ BYTE_W'(size_clamped);
                                pos_next  = POS_NUMBER;
                            end
                            POS_NUMBER:
                            begin
                                number_next = value;
                                xor_next    = xor_reg ^ value;
                                pos_next    = POS_CHECKSUM;
                            end
                            POS_CHECKSUM:
                            begin
                                checksum_next = value;
                                if (size_reg == '0)
                                begin
                                    pos_next   = POS_TYPE;
                                    state_next = S_CHECK;
                                end
                                else
                                begin
                                    pos_next = POS_PAYLOAD;
                                end
                            end
                            default:
                            begin
                                mem_we   = 1'b1;
                                xor_next = xor_reg ^ value;
                                if ((pay_idx + POS_W'(1)) >= POS_W'(size_reg))
                                begin
                                    pos_next   = POS_TYPE;
                                    state_next = S_CHECK;
                                end
                                else
                                begin
                                    pos_next = pos_reg + POS_W'(1);
                                end
                            end
                        endcase
                    end
                end
            end
            S_CHECK:
            begin
                match_next = (xor_reg == checksum_reg);
                cnt_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    // The forwarded header carries the incremented counters, which stay.
                    if (match_reg && (cnt_reg == C_PAVG))
                    begin
                        number_next   = number_reg + BYTE_W'(1);
                        checksum_next = checksum_reg + BYTE_W'(1);
                    end
                    if (match_reg ? (cnt_reg == match_end_cnt) : (cnt_reg == C_ERR_END))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and packet fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pos_reg         <= POS_TYPE;
            avg_reg         <= '0;
            type_reg        <= '0;
            size_reg        <= '0;
            number_reg      <= '0;
            checksum_reg    <= CHECKSUM_RESET;
            xor_reg         <= '0;
            match_reg       <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            dev_type_reg    <= BYTE_W'(1);
            parent_size_reg <= BYTE_W'(5);
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            avg_reg       <= avg_next;
            type_reg      <= type_next;
            size_reg      <= size_next;
            number_reg    <= number_next;
            checksum_reg  <= checksum_next;
            xor_reg       <= xor_next;
            match_reg     <= match_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_DEVICE_TYPE: dev_type_reg    <= cfg_data;
                    CFG_PARENT_SIZE: parent_size_reg <= cfg_data;
                    default:         dev_type_reg    <= dev_type_reg;
                endcase
            end
        end
    end

    // Output payload register; it only changes when a new byte is loaded.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dest_reg <= emit_dest;
            data_reg <= emit_data;
            eop_reg  <= emit_eop;
            last_reg <= match_reg ? (cnt_reg == match_end_cnt) : (cnt_reg == C_ERR_END);
        end
    end

    // Payload buffer with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[mem_waddr] <= value;
        end
        rd_data_reg <= payload_mem[mem_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign dest          = dest_reg;
    assign data          = data_reg;
    assign end_of_packet = eop_reg;
    assign last          = last_reg;

endmodule

>>> design/pcr_checker.sv
// Port-level assertions for the packet check and relay block, bound to its top level.
module pcr_checker
    import pcr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              op,
    input logic              out_valid,
    input logic              out_stall,
    input logic              dest,
    input logic [BYTE_W-1:0] data,
    input logic              end_of_packet,
    input logic              last
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dest) && $stable(data)
                                   && $stable(end_of_packet) && $stable(last))
        else $error("stalled result changed");

    // The final result of a request always closes an outgoing packet.
    a_last_eop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> end_of_packet)
        else $error("final result does not end a packet");

    // No new request is taken while a result byte other than the final one of an answer is out.
    a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("request taken in the middle of an outgoing burst");

    // A converter sample leaves the block ready for the next request.
    a_sample_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_SAMPLE) |=> !in_stall)
        else $error("sample request made the block busy");

endmodule

bind packet_check_and_relay pcr_checker u_pcr_checker (.*);

>>> dv/tb_packet_check_and_relay.sv
// Self-checking testbench for packet_check_and_relay: directed rows, then random packets.
module tb_packet_check_and_relay;
    import pcr_pkg::*;

    // Positions of the link parser within an incoming packet. Payload bytes
    // follow from POS_BODY onwards, one position per byte.
    localparam int POS_TYPE   = 0;
    localparam int POS_SIZE   = 1;
    localparam int POS_NUMBER = 2;
    localparam int POS_SUM    = 3;
    localparam int POS_BODY   = 4;

    // Number of requests in each random phase, and the number of phases.
    localparam int PHASE_ITEMS = 60;
    localparam int PHASES      = 4;

    // Cycles to let pass once nothing is due any more. The block compares the
    // checksum in its own check state and hands out a byte per cycle unless
    // stalled, so this settle time covers any request that gives no result.
    localparam int SETTLE_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [BYTE_W-1:0] value;
    logic              out_valid;
    logic              out_stall;
    logic              dest;
    logic [BYTE_W-1:0] data;
    logic              end_of_packet;
    logic              last;
    logic              cfg_write_en;
    logic              cfg_index;
    logic [BYTE_W-1:0] cfg_data;

    // One outgoing byte as the block should present it.
    typedef struct {
        logic              dest;
        logic [BYTE_W-1:0] data;
        logic              eop;
        logic              last;
    } relay_byte_t;

    // One row of the directed table. Where exp_count is negative the row is
    // left to the predictor alone; otherwise the number of result bytes and
    // the data of the final one are written out by hand.
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] value;
        int                exp_count;
        logic [BYTE_W-1:0] exp_tail;
    } dir_row_t;

    // Bytes the block still owes, oldest first.
    relay_byte_t due_bytes[$];

    // Copy of the configuration registers.
    logic [BYTE_W-1:0] node_type;
    logic [BYTE_W-1:0] parent_size;

    // Copy of the block's state.
    logic [BYTE_W-1:0] smoothed;
    int                rx_pos;
    logic [BYTE_W-1:0] rx_type;
    logic [SIZE_W-1:0] rx_size;
    logic [BYTE_W-1:0] rx_number;
    logic [BYTE_W-1:0] rx_sum;
    logic [BYTE_W-1:0] rx_xor;
    logic [BYTE_W-1:0] rx_payload [PAYLOAD_MAX];
    logic [BYTE_W-1:0] tail_byte;

    int  mismatch_count;
    int  items_sent;
    bit  quiet;

    relay_byte_t want_byte;

    // The directed part. The first row is a sample, which leaves the average
    // at 0x7F. Next comes an empty packet whose checksum is wrong, so the
    // node answers with an error packet ending in device_type ^ 0xFF. Last
    // comes a packet with size byte 0xFF, clamped to the full buffer, whose
    // payload makes the checksum match; its number and checksum of 0xFF wrap
    // to zero when forwarded, and it gives the largest answer of 25 bytes.
    dir_row_t dir_rows [0:24] = '{
        '{OP_SAMPLE, 8'hFF,  0, 8'h00},
        '{OP_LINK,   8'h00,  0, 8'h00},
        '{OP_LINK,   8'h00,  0, 8'h00},
        '{OP_LINK,   8'h01,  0, 8'h00},
        '{OP_LINK,   8'h00,  4, 8'hFE},
        '{OP_LINK,   8'hFF,  0, 8'h00},
        '{OP_LINK,   8'hFF,  0, 8'h00},
        '{OP_LINK,   8'hFF,  0, 8'h00},
        '{OP_LINK,   8'hFF,  0, 8'h00},
        '{OP_LINK,   8'hEF, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, -1, 8'h00},
        '{OP_LINK,   8'h00, 25, 8'h00}
    };

    packet_check_and_relay dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dest          (dest),
        .data          (data),
        .end_of_packet (end_of_packet),
        .last          (last),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling on the whole run; a correct run ends long before it.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Queues one expected byte; the final byte of an answer is marked later.
    function automatic void owe_byte(logic d, logic [BYTE_W-1:0] b, logic eop);
        relay_byte_t r;
        r.dest = d;
        r.data = b;
        r.eop  = eop;
        r.last = 1'b0;
        due_bytes.push_back(r);
    endfunction

    // Answers a completed packet: a sensor packet and the forwarded copy when
    // the checksum agrees, an error packet when it does not. Returns the
    // number of bytes queued.
    function automatic int answer_packet();
        int                n;
        logic [BYTE_W-1:0] sum;
        relay_byte_t       fin;
        n = 0;
        if (rx_xor == rx_sum)
        begin
            sum = node_type ^ parent_size ^ rx_number ^ smoothed;
            owe_byte(DEST_PARENT, node_type, 1'b0);
            owe_byte(DEST_PARENT, parent_size, 1'b0);
            owe_byte(DEST_PARENT, rx_number, 1'b0);
            owe_byte(DEST_PARENT, sum, 1'b0);
            owe_byte(DEST_PARENT, smoothed, 1'b1);
            // The bumped counters stay in the state for later packets.
            rx_number = rx_number + 8'd1;
            rx_sum    = rx_sum + 8'd1;
            owe_byte(DEST_NEIGHBOR, rx_type, 1'b0);
            owe_byte(DEST_NEIGHBOR, BYTE_W'(rx_size), 1'b0);
            owe_byte(DEST_NEIGHBOR, rx_number, 1'b0);
            owe_byte(DEST_NEIGHBOR, rx_sum, rx_size == 0);
            n = 9;
            for (int i = 0; i < int'(rx_size); i++)
            begin
                owe_byte(DEST_NEIGHBOR, rx_payload[i], i + 1 == int'(rx_size));
                n++;
            end
        end
        else
        begin
            owe_byte(DEST_PARENT, node_type, 1'b0);
            owe_byte(DEST_PARENT, ERR_SIZE_BYTE, 1'b0);
            owe_byte(DEST_PARENT, ERR_CODE_BYTE, 1'b0);
            owe_byte(DEST_PARENT, node_type ^ ERR_CODE_BYTE, 1'b1);
            n = 4;
        end
        fin = due_bytes.pop_back();
        fin.last = 1'b1;
        due_bytes.push_back(fin);
        tail_byte = fin.data;
        rx_pos = POS_TYPE;
        return n;
    endfunction

    // Steps the predicted state by one accepted request and queues whatever
    // bytes it causes. Returns their number.
    function automatic int parse_and_relay(logic req_op, logic [BYTE_W-1:0] v);
        int idx;
        if (req_op == OP_SAMPLE)
        begin
            smoothed = (smoothed >> 1) + (v >> 1);
            return 0;
        end
        case (rx_pos)
            POS_TYPE:
            begin
                rx_type = v;
                rx_xor  = v;
                rx_pos  = POS_SIZE;
            end
            POS_SIZE:
            begin
                // Sizes beyond the buffer are clamped as they arrive.
                rx_size = (int'(v) > PAYLOAD_MAX) ? SIZE_W'(PAYLOAD_MAX) : SIZE_W'(v);
                rx_xor  = rx_xor ^ BYTE_W'(rx_size);
                rx_pos  = POS_NUMBER;
            end
            POS_NUMBER:
            begin
                rx_number = v;
                rx_xor    = rx_xor ^ v;
                rx_pos    = POS_SUM;
            end
            POS_SUM:
            begin
                rx_sum = v;
                if (rx_size == 0)
                    return answer_packet();
                rx_pos = POS_BODY;
            end
            default:
            begin
                idx = rx_pos - POS_BODY;
                if (idx < PAYLOAD_MAX)
                begin
                    rx_payload[idx] = v;
                    rx_xor = rx_xor ^ v;
                end
                if (idx + 1 >= int'(rx_size))
                    return answer_packet();
                rx_pos++;
            end
        endcase
        return 0;
    endfunction

    // Offers one request, holds it until the block takes it, then predicts
    // its answer. Outside the quiet phase a random gap may follow; otherwise
    // valid stays high for the next request.
    task automatic send_item(input logic req_op, input logic [BYTE_W-1:0] v, output int n);
        in_valid <= 1'b1;
        op       <= req_op;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = parse_and_relay(req_op, v);
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    // Sends a well-formed packet with random content, now and then with a
    // bad checksum, with samples slipped in between its bytes. Any packet
    // left half-finished by stray bytes is first padded out so that the new
    // one starts at the type byte.
    task automatic send_packet(input bit corrupt);
        logic [BYTE_W-1:0] bytes [PAYLOAD_MAX + 4];
        logic [BYTE_W-1:0] raw_size;
        logic [BYTE_W-1:0] sum;
        int                len;
        int                n;
        while (rx_pos != POS_TYPE)
            send_item(OP_LINK, BYTE_W'($urandom), n);
        if ($urandom_range(0, 9) == 0)
            raw_size = BYTE_W'($urandom_range(PAYLOAD_MAX + 1, 255));
        else
            raw_size = BYTE_W'($urandom_range(0, PAYLOAD_MAX));
        len = (int'(raw_size) > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(raw_size);
        bytes[0] = BYTE_W'($urandom);
        bytes[1] = raw_size;
        bytes[2] = BYTE_W'($urandom);
        sum = bytes[0] ^ BYTE_W'(len) ^ bytes[2];
        for (int i = 0; i < len; i++)
        begin
            bytes[POS_BODY + i] = BYTE_W'($urandom);
            sum = sum ^ bytes[POS_BODY + i];
        end
        if (corrupt)
            sum = sum ^ BYTE_W'($urandom_range(1, 255));
        bytes[3] = sum;
        for (int i = 0; i < POS_BODY + len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(OP_SAMPLE, BYTE_W'($urandom), n);
            send_item(OP_LINK, bytes[i], n);
        end
    endtask

    // Lowers valid and waits until every owed byte has come out, then lets
    // the block settle so that a register write finds it idle.
    task automatic drain;
        in_valid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes both registers, device type first, and mirrors them.
    task automatic write_config(input logic [BYTE_W-1:0] type_byte,
                                input logic [BYTE_W-1:0] size_byte);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_DEVICE_TYPE;
        cfg_data     <= type_byte;
        @(posedge clk);
        node_type    = type_byte;
        cfg_index    <= CFG_PARENT_SIZE;
        cfg_data     <= size_byte;
        @(posedge clk);
        parent_size  = size_byte;
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every byte the block hands over is compared with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_bytes.size() == 0)
            begin
                $display("%0t: result byte with none due, expected nothing, got %h",
                         $time, data);
                mismatch_count++;
            end
            else
            begin
                want_byte = due_bytes.pop_front();
                report_field("dest", BYTE_W'(want_byte.dest), BYTE_W'(dest));
                report_field("data", want_byte.data, data);
                report_field("end_of_packet", BYTE_W'(want_byte.eop), BYTE_W'(end_of_packet));
                report_field("last", BYTE_W'(want_byte.last), BYTE_W'(last));
            end
        end
    end

    // Downstream stalls come in random bursts, sometimes followed
    // by a long calm stretch, and stop altogether in the quiet phase.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18))
                    @(posedge clk);
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(20, 60))
                        @(posedge clk);
            end
        end
    end

    // Main sequence: reset, the directed table under the reset values of the
    // registers, then random phases, each opened by a register write while
    // the block is idle. The first two phases use the register extremes.
    initial
    begin
        int                n;
        int                target;
        int                pick;
        logic [BYTE_W-1:0] phase_type [PHASES];
        logic [BYTE_W-1:0] phase_size [PHASES];

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_LINK;
        value        <= '0;
        cfg_write_en <= 1'b0;
        cfg_index    <= CFG_DEVICE_TYPE;
        cfg_data     <= '0;

        mismatch_count = 0;
        items_sent     = 0;
        quiet          = 1'b0;
        node_type      = 8'h01;
        parent_size    = 8'h05;
        smoothed       = '0;
        rx_pos         = POS_TYPE;
        rx_type        = '0;
        rx_size        = '0;
        rx_number      = '0;
        rx_sum         = CHECKSUM_RESET;
        rx_xor         = '0;
        tail_byte      = '0;

        phase_type[0] = 8'hFF;
        phase_size[0] = 8'h00;
        phase_type[1] = 8'h00;
        phase_size[1] = 8'hFF;
        for (int p = 2; p < PHASES; p++)
        begin
            phase_type[p] = BYTE_W'($urandom);
            phase_size[p] = BYTE_W'($urandom);
        end

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows. Hand-written answers are compared with what the
        // predictor makes of the same request.
        for (int r = 0; r < 25; r++)
        begin
            send_item(dir_rows[r].op, dir_rows[r].value, n);
            if (dir_rows[r].exp_count >= 0 &&
                (n != dir_rows[r].exp_count || (n > 0 && tail_byte !== dir_rows[r].exp_tail)))
            begin
                $display("%0t: row %0d expected %0d bytes ending %h, got %0d ending %h",
                         $time, r, dir_rows[r].exp_count, dir_rows[r].exp_tail, n, tail_byte);
                mismatch_count++;
            end
        end

        // Random phases. Most requests are well-formed packets; the rest are
        // lone samples, bad checksums and stray link bytes that break the
        // framing until the parser is padded back to the type byte.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            quiet = (p == PHASES - 1);
            write_config(phase_type[p], phase_size[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    repeat ($urandom_range(1, 3))
                        send_item(OP_LINK, BYTE_W'($urandom), n);
                end
                else if (pick == 1)
                    send_item(OP_SAMPLE, BYTE_W'($urandom), n);
                else
                    send_packet(pick < 5);
            end
        end

        drain();
        if (mismatch_count == 0 && due_bytes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
